// ===== sv/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== sv/lphm_pkg.sv =====
// shared types and constants of the linear probe hash map
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lphm_pkg;
  localparam int Buckets    = 256;
  localparam int KeyWidth   = 16;
  localparam int ValueWidth = 32;
  localparam int IdxW       = $clog2(Buckets);
  localparam int CntW       = IdxW + 1;
  localparam int SlotW      = KeyWidth + ValueWidth;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqLookup = 2'd1;
  localparam logic [1:0] ReqRemove = 2'd2;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [1:0]            req;
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] value;
  } lphm_cmd_t;
endpackage
`default_nettype wire

// ===== sv/lphm_ram.sv =====
// generic single-port-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lphm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/lphm_front.sv =====
// front end: takes request words and queues them for the engine
// depends on lphm_pkg
`timescale 1ns / 1ps
`default_nettype none
module lphm_front import lphm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lphm_cmd_t in_cmd_i,
  output logic           q_valid_o,
  input  wire logic      q_ready_i,
  output lphm_cmd_t      q_cmd_o
);
  // two-entry fifo
  lphm_cmd_t  buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = buf_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/lphm_engine.sv =====
// back end: probe walk and backward-shift delete over the slot memory
// depends on lphm_pkg and lphm_ram
`timescale 1ns / 1ps
`default_nettype none
module lphm_engine import lphm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wire lphm_cmd_t       cmd_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output logic [1:0]           status_o,
  output logic [ValueWidth-1:0] found_value_o,
  output logic [CntW-1:0]      entry_count_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_PRD, S_PCHK, S_SRD, S_SCHK, S_OUT
  } state_e;

  state_e                state_q;
  lphm_cmd_t             cmd_q;
  logic [IdxW-1:0]       idx_q, hole_q;
  logic [CntW-1:0]       n_q, occ_q;
  logic [Buckets-1:0]    valid_q;
  logic [1:0]            st_q;
  logic [ValueWidth-1:0] fv_q;

  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [SlotW-1:0]      wdata, rdata;
  logic [KeyWidth-1:0]   rkey;
  logic [ValueWidth-1:0] rval;
  logic [IdxW-1:0]       d_home, d_hole;
  logic [Buckets-1:0]    shift_mask;

  assign rkey   = rdata[SlotW-1 -: KeyWidth];
  assign rval   = rdata[ValueWidth-1:0];
  assign d_home = idx_q - rkey[IdxW-1:0];
  assign d_hole = idx_q - hole_q;
  // hole is empty and the moved member is valid, so toggling both moves the bit
  assign shift_mask = (Buckets'(1) << hole_q) | (Buckets'(1) << idx_q);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = {cmd_q.key, cmd_q.value};
    if (state_q == S_PCHK && cmd_q.req == ReqInsert) begin
      if (!valid_q[idx_q] || rkey == cmd_q.key) we = 1'b1;
    end else if (state_q == S_SCHK && n_q != CntW'(Buckets) && valid_q[idx_q] &&
                 d_home >= d_hole) begin
      we    = 1'b1;
      waddr = hole_q;
      wdata = rdata;
    end
  end

  lphm_ram #(.Width(SlotW), .Depth(Buckets)) u_slots (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(idx_q), .rdata_o(rdata)
  );

  assign cmd_ready_o   = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_OUT);
  assign status_o      = st_q;
  assign found_value_o = fv_q;
  assign entry_count_o = occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      occ_q   <= '0;
      cmd_q   <= '0;
      idx_q   <= '0;
      hole_q  <= '0;
      n_q     <= '0;
      st_q    <= StMiss;
      fv_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            idx_q   <= cmd_i.key[IdxW-1:0];
            n_q     <= '0;
            st_q    <= StMiss;
            fv_q    <= '0;
            state_q <= S_PRD;
          end
        end
        S_PRD: state_q <= S_PCHK;
        S_PCHK: begin
          if (!valid_q[idx_q]) begin
            // empty slot ends the walk
            if (cmd_q.req == ReqInsert) begin
              valid_q[idx_q] <= 1'b1;
              occ_q <= occ_q + 1'b1;
              st_q  <= StOk;
            end
            state_q <= S_OUT;
          end else if (rkey == cmd_q.key) begin
            case (cmd_q.req)
              ReqInsert: begin
                st_q <= StOk;
                state_q <= S_OUT;
              end
              ReqLookup: begin
                st_q <= StOk;
                fv_q <= rval;
                state_q <= S_OUT;
              end
              ReqRemove: begin
                st_q <= StOk;
                valid_q[idx_q] <= 1'b0;
                occ_q  <= occ_q - 1'b1;
                hole_q <= idx_q;
                idx_q  <= idx_q + 1'b1;
                n_q    <= CntW'(1);
                state_q <= S_SRD;
              end
              default: state_q <= S_OUT;
            endcase
          end else if (n_q == CntW'(Buckets - 1)) begin
            if (cmd_q.req == ReqInsert) st_q <= StFull;
            state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
            n_q   <= n_q + 1'b1;
            state_q <= S_PRD;
          end
        end
        S_SRD: state_q <= S_SCHK;
        S_SCHK: begin
          if (!valid_q[idx_q] || n_q == CntW'(Buckets)) begin
            state_q <= S_OUT;
          end else begin
            if (d_home >= d_hole) begin
              valid_q <= valid_q ^ shift_mask;
              hole_q  <= idx_q;
            end
            idx_q <= idx_q + 1'b1;
            n_q   <= n_q + 1'b1;
            state_q <= S_SRD;
          end
        end
        S_OUT: if (res_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/linear_probe_hash_map.sv =====
// top level of the linear probe hash map: request queue and probe engine
// depends on lphm_pkg, lphm_front, lphm_engine
`timescale 1ns / 1ps
`default_nettype none
// usage
// - s_axis carries request words: req_type, key, value; m_axis returns one
//   result word per request: status, found_value, entry_count
// - requests are served in order, one at a time; a two-word queue in front
//   takes new words while the engine works or its result waits
// - each slot probed from the home slot takes a read then a check state,
//   and a remove adds a read and a check for each slot walked by the
//   backward shift; each word also passes through the queue first and
//   ends in a result state
// - throughput is set by the single-port read of the slot memory, which
//   reads one slot at a time; the engine takes the next word in the cycle
//   after each result is taken
// - reset clears every valid bit and the occupancy count at once; the
//   key and value memory needs no clearing pass
// - a stalled m_axis holds the result; the queue then fills and s_axis
//   tready drops
module linear_probe_hash_map import lphm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // req_type [1:0], key [17:2], value [49:18], zero pad to 56 bits
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status [1:0], found_value [33:2], entry_count [42:34], zero pad to 48
  output logic [47:0]      m_axis_tdata
);
  lphm_cmd_t in_cmd, q_cmd;
  logic      q_valid, q_ready;
  logic [1:0]            status;
  logic [ValueWidth-1:0] found_value;
  logic [CntW-1:0]       entry_count;

  assign in_cmd.req   = s_axis_tdata[1:0];
  assign in_cmd.key   = s_axis_tdata[17:2];
  assign in_cmd.value = s_axis_tdata[49:18];

  lphm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  lphm_engine u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .status_o(status), .found_value_o(found_value), .entry_count_o(entry_count)
  );

  assign m_axis_tdata = {5'd0, entry_count, found_value, status};
endmodule
`default_nettype wire

// ===== sv/lphm_checker.sv =====
// port-level checks of the hash map, bound to the top level
// depends on assert_macros.svh and lphm_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lphm_sva import lphm_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  logic res_wait;
  assign res_wait = m_axis_tvalid && !m_axis_tready;

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, res_wait, m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMPL(a_cnt, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[42:34] <= 9'd256)
  `ASSERT_IMPL(a_st, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[1:0] <= StFull)
  `ASSERT_IMPL(a_fv, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1:0] != StOk, m_axis_tdata[33:2] == 32'd0)
endmodule

bind linear_probe_hash_map lphm_sva u_chk (.*);
`default_nettype wire
